### design/lrtc_pkg.sv
// lrtc_pkg: shared types and constants for the record tag cache.
// Used by lrtc_cell and lru_record_tag_cache_top; depends on nothing.
`default_nettype none

package lrtc_pkg;

  // Geometry
  localparam int ENTRIES  = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int REC_W    = 48;
  localparam int AGE_W    = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HIT_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT_FAIL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS_OK   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS_FAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic             func;
    logic [REC_W-1:0] record_number;
    logic             fetch_ok;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                success;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [REC_W-1:0]    evicted_record;
  } out_item_t;

  // Running replacement candidate handed from cell to cell
  typedef struct packed {
    logic             has_free;
    logic [IDX_W-1:0] free_idx;
    logic             has_vic;
    logic [IDX_W-1:0] vic_idx;
    logic [AGE_W-1:0] vic_age;
    logic [REC_W-1:0] vic_tag;
  } cand_t;

  // Write controls broadcast to every cell
  typedef struct packed {
    logic             clr;
    logic             wr_new;
    logic             wr_age;
    logic [REC_W-1:0] tag;
    logic             ok;
    logic [AGE_W-1:0] age;
  } cell_ctl_t;

  // Lookup status from one cell
  typedef struct packed {
    logic hit;
    logic hit_ok;
  } cell_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_FILL
  } fsm_t;

endpackage

`default_nettype wire

### design/lrtc_cell.sv
// lrtc_cell: one cache entry (tag, used, fetch outcome, age) with its tag
// compare and one registered step of the replacement candidate scan. Uses lrtc_pkg.
`default_nettype none

module lrtc_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  [lrtc_pkg::IDX_W-1:0] cell_idx,
  input  wire                       sel,
  input  lrtc_pkg::cell_ctl_t       ctl,
  input  wire  [lrtc_pkg::REC_W-1:0] key,
  output lrtc_pkg::cell_st_t        st,
  input  lrtc_pkg::cand_t           cand_in,
  output lrtc_pkg::cand_t           cand_out
);
  import lrtc_pkg::*;

  logic             used_r;
  logic [REC_W-1:0] tag_r;
  logic             ok_r;
  logic [AGE_W-1:0] age_r;
  cand_t            cand_r;
  cand_t            cand_nxt;

  // Hold the used bit; clear drops every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (ctl.clr) begin
      used_r <= 1'b0;
    end else if (sel && ctl.wr_new) begin
      used_r <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (sel && ctl.wr_new) begin
      tag_r <= ctl.tag;
      ok_r  <= ctl.ok;
    end
    if (sel && (ctl.wr_new || ctl.wr_age)) begin
      age_r <= ctl.age;
    end
  end

  // Tag compare
  assign st.hit    = used_r && (tag_r == key);
  assign st.hit_ok = used_r && (tag_r == key) && ok_r;

  // Merge this entry into the candidate: lowest free slot, else oldest age,
  // lowest tag on equal ages
  always_comb begin
    cand_nxt = cand_in;
    if (!used_r) begin
      if (!cand_in.has_free) begin
        cand_nxt.has_free = 1'b1;
        cand_nxt.free_idx = cell_idx;
      end
    end else if (!cand_in.has_vic || (age_r < cand_in.vic_age) ||
                 ((age_r == cand_in.vic_age) && (tag_r < cand_in.vic_tag))) begin
      cand_nxt.has_vic = 1'b1;
      cand_nxt.vic_idx = cell_idx;
      cand_nxt.vic_age = age_r;
      cand_nxt.vic_tag = tag_r;
    end
  end

  // Advance the candidate to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

`default_nettype wire

### design/lru_record_tag_cache_top.sv
// lru_record_tag_cache_top: fully associative LRU record tag cache built as
// a chain of lrtc_cell entries plus a small sequencer. Uses lrtc_pkg, lrtc_cell.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-------------------------------
//   input    | in_item                       | taken when start & !busy
//   result   | out_item                      | out_strobe, one cycle, no stall
//   config   | cfg_wdata (total_records)     | written when cfg_we
//
// Clear, out-of-range and hit transactions go through accept, then tag
// compare across all cells in parallel; the result shows the cycle after.
// A miss adds a sweep state while the replacement candidate ripples down
// the cell chain, then a fill state that writes the chosen entry.
// Reset (rst_n low, synchronous) empties the cache and zeroes the counter
// and total_records. Results cannot be held off; one transaction at a time.
`default_nettype none

module lru_record_tag_cache_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  lrtc_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output lrtc_pkg::out_item_t         out_item,
  input  wire                         cfg_we,
  input  wire  [lrtc_pkg::REC_W-1:0]  cfg_wdata
);
  import lrtc_pkg::*;

  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(ENTRIES - 1);

  fsm_t             state_r, state_nxt;
  in_item_t         req_r;
  logic [REC_W-1:0] total_r;
  logic [AGE_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] sel_idx;
  logic [ENTRIES-1:0] sel_vec;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] hit_ok_vec;
  cell_st_t         cell_st [ENTRIES];
  cand_t            cand    [ENTRIES+1];
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] fill_idx;
  logic             hit_any;
  logic             hit_ok_any;
  logic             out_of_range;
  cand_t            fin;

  // Cell chain
  assign cand[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel_vec[g]    = (sel_idx == IDX_W'(g));
    assign hit_vec[g]    = cell_st[g].hit;
    assign hit_ok_vec[g] = cell_st[g].hit_ok;

    lrtc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .sel      (sel_vec[g]),
      .ctl      (ctl),
      .key      (req_r.record_number),
      .st       (cell_st[g]),
      .cand_in  (cand[g]),
      .cand_out (cand[g+1])
    );
  end

  // Encode the matching entry (tags are unique, so at most one hits)
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit_any      = |hit_vec;
  assign hit_ok_any   = |hit_ok_vec;
  assign out_of_range = (req_r.record_number >= total_r);
  assign fin          = cand[ENTRIES];
  assign fill_idx     = fin.has_free ? fin.free_idx : fin.vic_idx;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
    end
  end

  // Capture the transaction on accept
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_item;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      sweep_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      sweep_r      <= sweep_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // Sequencer: next state, cell writes, result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sweep_nxt      = sweep_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    sel_idx        = hit_idx;
    ctl.clr        = 1'b0;
    ctl.wr_new     = 1'b0;
    ctl.wr_age     = 1'b0;
    ctl.tag        = req_r.record_number;
    ctl.ok         = req_r.fetch_ok;
    ctl.age        = count_r + AGE_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (req_r.func == FUNC_CLEAR) begin
          ctl.clr             = 1'b1;
          count_nxt           = '0;
          out_strobe_nxt      = 1'b1;
          out_item_nxt.status = ST_CLEARED;
          state_nxt           = S_IDLE;
        end else if (out_of_range) begin
          out_strobe_nxt      = 1'b1;
          out_item_nxt.status = ST_RANGE;
          state_nxt           = S_IDLE;
        end else if (hit_any) begin
          ctl.wr_age           = 1'b1;
          count_nxt            = count_r + AGE_W'(1);
          out_strobe_nxt       = 1'b1;
          out_item_nxt.status  = hit_ok_any ? ST_HIT_OK : ST_HIT_FAIL;
          out_item_nxt.success = hit_ok_any;
          out_item_nxt.slot    = SLOT_W'(hit_idx);
          state_nxt            = S_IDLE;
        end else begin
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // Let the candidate pass through every cell
        if (sweep_r == SWEEP_LAST) begin
          state_nxt = S_FILL;
        end else begin
          sweep_nxt = sweep_r + IDX_W'(1);
        end
      end
      S_FILL: begin
        sel_idx                     = fill_idx;
        ctl.wr_new                  = 1'b1;
        count_nxt                   = count_r + AGE_W'(1);
        out_strobe_nxt              = 1'b1;
        out_item_nxt.status         = req_r.fetch_ok ? ST_MISS_OK : ST_MISS_FAIL;
        out_item_nxt.success        = req_r.fetch_ok;
        out_item_nxt.slot           = SLOT_W'(fill_idx);
        out_item_nxt.evicted        = !fin.has_free;
        out_item_nxt.evicted_record = fin.has_free ? '0 : fin.vic_tag;
        state_nxt                   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire
